### rtl/sswd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sswd_pkg
// Shared types and constants of the sensor scan and wall detect block.
// ----------------------------------------------------------------------------
package sswd_pkg;

   localparam int SAMPLE_W  = 12;   // distance sample
   localparam int BATT_W    = 14;   // battery voltage in mV
   localparam int REG_W     = 12;   // every configuration register
   localparam int ERR_W     = 13;   // signed steering error
   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 3;
   localparam int PHASE_W   = 2;
   localparam int BAR_W     = 4;    // holds a bar count of up to 15
   localparam int PROD_W    = 20;   // battery compare products

   typedef enum logic [PHASE_W-1:0] {
      PH_FRONT_RIGHT = 2'd0,
      PH_FRONT_LEFT  = 2'd1,
      PH_RIGHT       = 2'd2,
      PH_LEFT        = 2'd3
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WALL_FRONT_RIGHT = 3'd0,
      REG_WALL_FRONT_LEFT  = 3'd1,
      REG_WALL_RIGHT       = 3'd2,
      REG_WALL_LEFT        = 3'd3,
      REG_CTRL_RIGHT       = 3'd4,
      REG_CTRL_LEFT        = 3'd5,
      REG_REF_RIGHT        = 3'd6,
      REG_REF_LEFT         = 3'd7
   } reg_index_type;

   localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
      12'd300, 12'd300, 12'd300, 12'd300, 12'd500, 12'd500, 12'd800, 12'd800
   };

endpackage
`default_nettype wire

### rtl/sensor_scan_wall_detect.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_scan_wall_detect
// Four-channel distance scan with wall flags, side steering error and a
// battery bar LED.
// ----------------------------------------------------------------------------
// Each accepted request word is one scan tick. An internal phase counter says
// which sensor the sample belongs to, stepping front right, front left, right,
// left and around again; the response word carries the phase handled and the
// flags, errors and LED as they stand after that tick. A wall flag is set when
// its sample is strictly above the wall threshold. The right and left ticks
// also set a steering-valid flag and sample minus reference when the sample is
// above the control threshold, and clear both otherwise. Each left tick steps
// a bar counter 0..BAR_STEPS (wrapping) and lights the LED when the battery
// bar level is above the new count. Throughput is one word per clock: all
// work is a few compares and subtracts between the request port and the
// response register, and a new request is taken whenever the response
// register is empty or being read in the same cycle.
// Configuration writes take effect at once and should be made while idle.
// ----------------------------------------------------------------------------
module sensor_scan_wall_detect #(
   parameter int BATT_LOW_MV  = 3000,
   parameter int BATT_HIGH_MV = 4200,
   parameter int BAR_STEPS    = 10
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   // configuration write port
   input  wire logic                                csr_write_en,
   input  wire logic [sswd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [sswd_pkg::REG_W-1:0]          csr_wdata,

   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [sswd_pkg::SAMPLE_W-1:0]       req_sample,
   input  wire logic [sswd_pkg::BATT_W-1:0]         req_battery_mv,

   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [sswd_pkg::PHASE_W-1:0]             rsp_phase,
   output logic                                     rsp_wall_front_right,
   output logic                                     rsp_wall_front_left,
   output logic                                     rsp_wall_right,
   output logic                                     rsp_wall_left,
   output logic                                     rsp_ctrl_valid_right,
   output logic                                     rsp_ctrl_valid_left,
   output logic signed [sswd_pkg::ERR_W-1:0]        rsp_err_right,
   output logic signed [sswd_pkg::ERR_W-1:0]        rsp_err_left,
   output logic                                     rsp_battery_led
);

   // battery span; an empty span means any voltage above the low level lights
   localparam bit EMPTY_SPAN = (BATT_HIGH_MV <= BATT_LOW_MV);
   localparam int SPAN       = EMPTY_SPAN ? 1 : (BATT_HIGH_MV - BATT_LOW_MV);

   // configuration registers
   logic [sswd_pkg::REG_W-1:0] cfg_ff [sswd_pkg::NUM_REGS];

   // scan state; flags, errors and led double as the response payload
   sswd_pkg::phase_type              scan_phase_ff, scan_phase_in;
   logic [sswd_pkg::BAR_W-1:0]       bar_ff, bar_in;
   logic [3:0]                       wall_ff, wall_in;
   logic [1:0]                       ctrl_ff, ctrl_in;
   logic signed [sswd_pkg::ERR_W-1:0] err_right_ff, err_right_in;
   logic signed [sswd_pkg::ERR_W-1:0] err_left_ff, err_left_in;
   logic                             led_ff, led_in;
   sswd_pkg::phase_type              rsp_phase_ff;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic                             req_accept;
   logic [sswd_pkg::BAR_W:0]         bar_plus;
   logic [sswd_pkg::BAR_W-1:0]       bar_wrap;
   logic [sswd_pkg::PROD_W-1:0]      batt_lhs;
   logic [sswd_pkg::PROD_W-1:0]      batt_rhs;
   logic                             batt_above_low;
   logic                             led_calc;

   // ---------------------------------------------------------------- handshake
   // hold off only when a response waits and is not taken this cycle
   assign req_stall    = rsp_valid_ff & rsp_stall;
   assign req_accept   = req_valid & ~req_stall;
   assign rsp_valid_in = req_accept | (rsp_valid_ff & rsp_stall);

   // ---------------------------------------------------------------- battery
   // bar counter wraps past the last step
   assign bar_plus       = {1'b0, bar_ff} + 1'b1;
   assign bar_wrap       = (int'(bar_plus) > BAR_STEPS) ? '0
                                                        : bar_plus[sswd_pkg::BAR_W-1:0];
   // floor(d*steps/span) > count  <=>  d*steps >= (count+1)*span
   assign batt_above_low = (int'(req_battery_mv) > BATT_LOW_MV);
   assign batt_lhs       = (sswd_pkg::PROD_W'(req_battery_mv)
                            - sswd_pkg::PROD_W'(BATT_LOW_MV))
                           * sswd_pkg::PROD_W'(BAR_STEPS);
   assign batt_rhs       = (sswd_pkg::PROD_W'(bar_wrap) + 1'b1)
                           * sswd_pkg::PROD_W'(SPAN);

   always_comb begin
      if (!batt_above_low) begin
         led_calc = 1'b0;
      end else if (EMPTY_SPAN) begin
         led_calc = 1'b1;
      end else begin
         led_calc = (batt_lhs >= batt_rhs);
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      scan_phase_in = scan_phase_ff;
      bar_in        = bar_ff;
      wall_in       = wall_ff;
      ctrl_in       = ctrl_ff;
      err_right_in  = err_right_ff;
      err_left_in   = err_left_ff;
      led_in        = led_ff;
      if (req_accept) begin
         scan_phase_in = sswd_pkg::phase_type'(2'(scan_phase_ff + 2'd1));
         // wall flag of the channel this tick belongs to
         wall_in[scan_phase_ff] = (req_sample > cfg_ff[{1'b0, scan_phase_ff}]);
         case (scan_phase_ff)
            sswd_pkg::PH_RIGHT: begin
               if (req_sample > cfg_ff[sswd_pkg::REG_CTRL_RIGHT]) begin
                  ctrl_in[0]   = 1'b1;
                  err_right_in = $signed({1'b0, req_sample})
                                 - $signed({1'b0, cfg_ff[sswd_pkg::REG_REF_RIGHT]});
               end else begin
                  ctrl_in[0]   = 1'b0;
                  err_right_in = '0;
               end
            end
            sswd_pkg::PH_LEFT: begin
               if (req_sample > cfg_ff[sswd_pkg::REG_CTRL_LEFT]) begin
                  ctrl_in[1]  = 1'b1;
                  err_left_in = $signed({1'b0, req_sample})
                                - $signed({1'b0, cfg_ff[sswd_pkg::REG_REF_LEFT]});
               end else begin
                  ctrl_in[1]  = 1'b0;
                  err_left_in = '0;
               end
               bar_in = bar_wrap;
               led_in = led_calc;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sswd_pkg::NUM_REGS; i++) begin
            cfg_ff[i] <= sswd_pkg::REG_RESET[i];
         end
      end else if (csr_write_en) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_phase_ff <= sswd_pkg::PH_FRONT_RIGHT;
         rsp_phase_ff  <= sswd_pkg::PH_FRONT_RIGHT;
         bar_ff        <= '0;
         wall_ff       <= '0;
         ctrl_ff       <= '0;
         err_right_ff  <= '0;
         err_left_ff   <= '0;
         led_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         scan_phase_ff <= scan_phase_in;
         if (req_accept) begin
            rsp_phase_ff <= scan_phase_ff;
         end
         bar_ff       <= bar_in;
         wall_ff      <= wall_in;
         ctrl_ff      <= ctrl_in;
         err_right_ff <= err_right_in;
         err_left_ff  <= err_left_in;
         led_ff       <= led_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------- outputs
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_phase            = rsp_phase_ff;
   assign rsp_wall_front_right = wall_ff[0];
   assign rsp_wall_front_left  = wall_ff[1];
   assign rsp_wall_right       = wall_ff[2];
   assign rsp_wall_left        = wall_ff[3];
   assign rsp_ctrl_valid_right = ctrl_ff[0];
   assign rsp_ctrl_valid_left  = ctrl_ff[1];
   assign rsp_err_right        = err_right_ff;
   assign rsp_err_left         = err_left_ff;
   assign rsp_battery_led      = led_ff;

endmodule
`default_nettype wire

### rtl/sswd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sswd_checker
// Port-level assertions for the sensor scan and wall detect block.
// ----------------------------------------------------------------------------
module sswd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_stall,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic [sswd_pkg::PHASE_W-1:0]    rsp_phase,
   input wire logic                            rsp_wall_front_right,
   input wire logic                            rsp_ctrl_valid_right,
   input wire logic signed [sswd_pkg::ERR_W-1:0] rsp_err_right,
   input wire logic                            rsp_battery_led
);

   // a stall toward the request side only while a response waits
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled with no pending response");

   // back-to-back responses walk the phase by one
   a_phase_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) ##1 rsp_valid |->
      rsp_phase == 2'($past(rsp_phase) + 2'd1))
      else $error("response phase did not advance by one");

   // the led moves only on a left tick
   a_led_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) ##1
      (rsp_valid && rsp_phase != sswd_pkg::PH_LEFT) |-> $stable(rsp_battery_led))
      else $error("battery led changed outside the left phase");

   // front right flag held on other ticks
   a_front_right_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall) ##1
      (rsp_valid && rsp_phase != sswd_pkg::PH_FRONT_RIGHT) |->
      $stable(rsp_wall_front_right))
      else $error("front right wall flag changed outside its phase");

   // a nonzero error only when steering is valid
   a_err_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_err_right != '0) |-> rsp_ctrl_valid_right)
      else $error("right error nonzero without valid flag");

endmodule

bind sensor_scan_wall_detect sswd_checker u_sswd_checker (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_phase            (rsp_phase),
   .rsp_wall_front_right (rsp_wall_front_right),
   .rsp_ctrl_valid_right (rsp_ctrl_valid_right),
   .rsp_err_right        (rsp_err_right),
   .rsp_battery_led      (rsp_battery_led)
);
`default_nettype wire
